### sv/esc_pkg.sv
// Shared types and constants for the end-stop crossing scanner.
package esc_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SEEK  = 3'd1,
    PH_CLEAR = 3'd2,
    PH_DONE  = 3'd3,
    PH_ERR   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_EDGE   = 2'd1,
    MODE_SAMPLE = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_PASSES_WANTED  = 2'd0,
    REG_CLEAR_STEPS    = 2'd1,
    REG_TIMEOUT_MS     = 2'd2,
    REG_START_NEGATIVE = 2'd3
  } reg_idx_t;

  localparam logic [7:0]  PASSES_WANTED_RST  = 8'd1;
  localparam logic [15:0] CLEAR_STEPS_RST    = 16'd100;
  localparam logic [31:0] TIMEOUT_MS_RST     = 32'd30000;
  localparam logic        START_NEGATIVE_RST = 1'b0;

  localparam int PASSES_MAX = 255;

  typedef struct packed {
    logic [7:0]  passes_wanted;
    logic [15:0] clear_steps;
    logic [31:0] timeout_ms;
    logic        start_negative;
  } cfg_t;

  typedef struct packed {
    logic [15:0] edge_count;
    logic [7:0]  passes_count;
    logic [31:0] region_width;
    logic [31:0] leave_position;
    logic [31:0] enter_position;
    logic        pass_done;
    logic [2:0]  phase;
    logic        move_negative;
    logic        stop_motion;
    logic        start_rotate;
  } result_t;

endpackage

### sv/endstop_crossing_scanner_top.sv
// Top level of the end-stop crossing scanner: input register, scan state, result register.
//
// Usage:
//   in_*   stream of words: tuser carries mode and entered, tdata the position.
//          mode 0 starts a scan, 1 is an end-stop edge, 2 a position sample,
//          3 a millisecond tick.
//   out_*  one result word per input word, in order, packed into tdata.
//   cfg_*  APB-style register port: passes_wanted at 0x0, clear_steps at 0x4,
//          timeout_ms at 0x8, start_negative at 0xC. Write only while idle.
// Timing:
//   A word accepted into the input register is evaluated against the scan
//   state when it advances, and its result and the new state are registered
//   together in the result register and the state registers. One word per
//   cycle sustained while out_tready is high; the step logic is combinational.
// Reset:
//   rst_n low clears the valid flags of both registers, puts the scan in idle
//   with zeroed counters and loads the register defaults.
// Stalls:
//   With out_tready low the result register holds, one more word waits in the
//   input register, and in_tready drops until the result is taken.
module endstop_crossing_scanner_top #(
  parameter int POS_BITS        = 32,
  parameter int EDGE_COUNT_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [31:0] position
  input  logic [2:0]   in_tuser,   // [1:0] mode, [2] entered
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] start_rotate, [1] stop_motion, [2] move_negative, [5:3] phase,
  // [6] pass_done, [38:7] enter_position, [70:39] leave_position,
  // [102:71] region_width, [110:103] passes_count, [126:111] edge_count,
  // [127] zero
  output logic [127:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  esc_pkg::cfg_t cfg;

  logic                         in_valid_r;
  esc_pkg::mode_t               in_mode_r;
  logic                         in_entered_r;
  logic signed [POS_BITS-1:0]   in_pos_r;
  logic                         in_acc;
  logic                         adv;

  esc_pkg::phase_t              phase_r, phase_nxt;
  logic                         heading_r, heading_nxt;
  logic                         enter_seen_r, enter_seen_nxt;
  logic signed [POS_BITS-1:0]   enter_mark_r, enter_mark_nxt;
  logic signed [POS_BITS-1:0]   clear_origin_r, clear_origin_nxt;
  logic [7:0]                   passes_r, passes_nxt;
  logic [EDGE_COUNT_BITS-1:0]   edges_r, edges_nxt;
  logic [31:0]                  elapsed_r, elapsed_nxt;

  esc_pkg::result_t             res_nxt, res_r;
  logic                         out_valid_r;

  esc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  esc_step #(
    .POS_BITS        (POS_BITS),
    .EDGE_COUNT_BITS (EDGE_COUNT_BITS)
  ) u_step (
    .cfg              (cfg),
    .mode             (in_mode_r),
    .entered          (in_entered_r),
    .pos              (in_pos_r),
    .phase            (phase_r),
    .heading          (heading_r),
    .enter_seen       (enter_seen_r),
    .enter_mark       (enter_mark_r),
    .clear_origin     (clear_origin_r),
    .passes           (passes_r),
    .edges            (edges_r),
    .elapsed          (elapsed_r),
    .phase_nxt        (phase_nxt),
    .heading_nxt      (heading_nxt),
    .enter_seen_nxt   (enter_seen_nxt),
    .enter_mark_nxt   (enter_mark_nxt),
    .clear_origin_nxt (clear_origin_nxt),
    .passes_nxt       (passes_nxt),
    .edges_nxt        (edges_nxt),
    .elapsed_nxt      (elapsed_nxt),
    .res              (res_nxt)
  );

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_mode_r    <= esc_pkg::mode_t'(in_tuser[1:0]);
      in_entered_r <= in_tuser[2];
      in_pos_r     <= in_tdata[POS_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= esc_pkg::PH_IDLE;
      heading_r      <= 1'b0;
      enter_seen_r   <= 1'b0;
      enter_mark_r   <= '0;
      clear_origin_r <= '0;
      passes_r       <= '0;
      edges_r        <= '0;
      elapsed_r      <= '0;
    end else if (adv) begin
      phase_r        <= phase_nxt;
      heading_r      <= heading_nxt;
      enter_seen_r   <= enter_seen_nxt;
      enter_mark_r   <= enter_mark_nxt;
      clear_origin_r <= clear_origin_nxt;
      passes_r       <= passes_nxt;
      edges_r        <= edges_nxt;
      elapsed_r      <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

endmodule

### sv/esc_cfg.sv
// APB-style configuration registers of the end-stop crossing scanner.
module esc_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output esc_pkg::cfg_t cfg
);

  esc_pkg::cfg_t    cfg_r;
  esc_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = esc_pkg::reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.passes_wanted  <= esc_pkg::PASSES_WANTED_RST;
      cfg_r.clear_steps    <= esc_pkg::CLEAR_STEPS_RST;
      cfg_r.timeout_ms     <= esc_pkg::TIMEOUT_MS_RST;
      cfg_r.start_negative <= esc_pkg::START_NEGATIVE_RST;
    end else if (wr_en) begin
      unique case (idx)
        esc_pkg::REG_PASSES_WANTED:  cfg_r.passes_wanted  <= pwdata[7:0];
        esc_pkg::REG_CLEAR_STEPS:    cfg_r.clear_steps    <= pwdata[15:0];
        esc_pkg::REG_TIMEOUT_MS:     cfg_r.timeout_ms     <= pwdata;
        esc_pkg::REG_START_NEGATIVE: cfg_r.start_negative <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      esc_pkg::REG_PASSES_WANTED:  prdata = {24'd0, cfg_r.passes_wanted};
      esc_pkg::REG_CLEAR_STEPS:    prdata = {16'd0, cfg_r.clear_steps};
      esc_pkg::REG_TIMEOUT_MS:     prdata = cfg_r.timeout_ms;
      esc_pkg::REG_START_NEGATIVE: prdata = {31'd0, cfg_r.start_negative};
    endcase
  end

endmodule

### sv/esc_step.sv
// Per-word next-state and result logic of the end-stop crossing scanner.
module esc_step #(
  parameter int POS_BITS        = 32,
  parameter int EDGE_COUNT_BITS = 16
) (
  input  esc_pkg::cfg_t                cfg,
  input  esc_pkg::mode_t               mode,
  input  logic                         entered,
  input  logic signed [POS_BITS-1:0]   pos,
  input  esc_pkg::phase_t              phase,
  input  logic                         heading,
  input  logic                         enter_seen,
  input  logic signed [POS_BITS-1:0]   enter_mark,
  input  logic signed [POS_BITS-1:0]   clear_origin,
  input  logic [7:0]                   passes,
  input  logic [EDGE_COUNT_BITS-1:0]   edges,
  input  logic [31:0]                  elapsed,
  output esc_pkg::phase_t              phase_nxt,
  output logic                         heading_nxt,
  output logic                         enter_seen_nxt,
  output logic signed [POS_BITS-1:0]   enter_mark_nxt,
  output logic signed [POS_BITS-1:0]   clear_origin_nxt,
  output logic [7:0]                   passes_nxt,
  output logic [EDGE_COUNT_BITS-1:0]   edges_nxt,
  output logic [31:0]                  elapsed_nxt,
  output esc_pkg::result_t             res
);

  localparam int EW = (EDGE_COUNT_BITS > 16) ? EDGE_COUNT_BITS : 16;

  logic signed [POS_BITS:0]   width_diff;
  logic signed [POS_BITS:0]   clr_diff;
  logic [POS_BITS-1:0]        width_abs;
  logic [POS_BITS-1:0]        clr_abs;
  logic [31:0]                elapsed_inc;
  logic [EW-1:0]              edges_ext;

  assign width_diff = (POS_BITS+1)'(enter_mark) - (POS_BITS+1)'(pos);
  assign width_abs  = width_diff[POS_BITS] ? POS_BITS'(-width_diff)
                                           : POS_BITS'(width_diff);
  assign clr_diff   = (POS_BITS+1)'(pos) - (POS_BITS+1)'(clear_origin);
  assign clr_abs    = clr_diff[POS_BITS] ? POS_BITS'(-clr_diff)
                                         : POS_BITS'(clr_diff);
  assign elapsed_inc = (elapsed != '1) ? elapsed + 32'd1 : elapsed;
  assign edges_ext   = EW'(edges_nxt);

  always_comb begin
    phase_nxt        = phase;
    heading_nxt      = heading;
    enter_seen_nxt   = enter_seen;
    enter_mark_nxt   = enter_mark;
    clear_origin_nxt = clear_origin;
    passes_nxt       = passes;
    edges_nxt        = edges;
    elapsed_nxt      = elapsed;
    res              = '0;

    unique case (mode)
      esc_pkg::MODE_START: begin
        passes_nxt       = '0;
        edges_nxt        = '0;
        enter_seen_nxt   = 1'b0;
        elapsed_nxt      = '0;
        heading_nxt      = cfg.start_negative;
        phase_nxt        = esc_pkg::PH_SEEK;
        res.start_rotate = 1'b1;
      end
      esc_pkg::MODE_EDGE: begin
        if (phase == esc_pkg::PH_SEEK) begin
          if (edges != '1) edges_nxt = edges + EDGE_COUNT_BITS'(1);
          if (entered) begin
            enter_seen_nxt = 1'b1;
            enter_mark_nxt = pos;
          end else if (enter_seen) begin
            enter_seen_nxt = 1'b0;
            if (passes != 8'(esc_pkg::PASSES_MAX)) passes_nxt = passes + 8'd1;
            res.pass_done      = 1'b1;
            res.enter_position = 32'(enter_mark);
            res.leave_position = 32'(pos);
            res.region_width   = 32'(width_abs);
            clear_origin_nxt   = pos;
            phase_nxt          = esc_pkg::PH_CLEAR;
          end
        end
      end
      esc_pkg::MODE_SAMPLE: begin
        if (phase == esc_pkg::PH_CLEAR &&
            clr_abs >= POS_BITS'(cfg.clear_steps)) begin
          res.stop_motion = 1'b1;
          if (passes >= cfg.passes_wanted) begin
            phase_nxt = esc_pkg::PH_DONE;
          end else begin
            heading_nxt      = ~heading;
            enter_seen_nxt   = 1'b0;
            res.start_rotate = 1'b1;
            phase_nxt        = esc_pkg::PH_SEEK;
          end
        end
      end
      esc_pkg::MODE_TICK: begin
        if (phase == esc_pkg::PH_SEEK || phase == esc_pkg::PH_CLEAR) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc > cfg.timeout_ms) begin
            res.stop_motion = 1'b1;
            phase_nxt       = esc_pkg::PH_ERR;
          end
        end
      end
    endcase

    res.move_negative = heading_nxt;
    res.phase         = phase_nxt;
    res.passes_count  = passes_nxt;
    res.edge_count    = edges_ext[15:0];
  end

endmodule
